[sv/mkd_pkg.sv]
// ---------------------------------------------------------------------------
// Morse keying decoder package
// Shared result types, character codes and the Morse letter table.
// ---------------------------------------------------------------------------
`default_nettype none

package mkd_pkg;

  localparam int DOT_W     = 12;
  localparam int CHAR_W    = 7;
  localparam int PAT_W     = 7;
  localparam int OUTQ_DEPTH = 3;

  localparam logic [DOT_W-1:0]  DOT_RESET    = 12'd100;
  localparam logic [CHAR_W-1:0] CHAR_SPACE   = 7'h20;
  localparam logic [CHAR_W-1:0] CHAR_UNKNOWN = 7'h3F;
  localparam logic [CHAR_W-1:0] CHAR_NONE    = 7'h00;

  // One result item as it leaves the block.
  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              char_valid;
    logic              last_of_item;
    logic              end_of_text;
  } res_t;

  // Everything one input item produces: up to two result items.
  typedef struct packed {
    logic [1:0]     n;
    res_t [1:0]     res;
  } step_res_t;

  // Letter lookup, index is (1 << length) | pattern for lengths 1 to 4.
  // A zero return means the pattern is not a letter.
  function automatic logic [CHAR_W-1:0] letter_of(input logic [4:0] idx);
    logic [CHAR_W-1:0] ch;
    unique case (idx)
      5'd2:    ch = 7'h45;  // E
      5'd3:    ch = 7'h54;  // T
      5'd4:    ch = 7'h49;  // I
      5'd5:    ch = 7'h41;  // A
      5'd6:    ch = 7'h4E;  // N
      5'd7:    ch = 7'h4D;  // M
      5'd8:    ch = 7'h53;  // S
      5'd9:    ch = 7'h55;  // U
      5'd10:   ch = 7'h52;  // R
      5'd11:   ch = 7'h57;  // W
      5'd12:   ch = 7'h44;  // D
      5'd13:   ch = 7'h4B;  // K
      5'd14:   ch = 7'h47;  // G
      5'd15:   ch = 7'h4F;  // O
      5'd16:   ch = 7'h48;  // H
      5'd17:   ch = 7'h56;  // V
      5'd18:   ch = 7'h46;  // F
      5'd20:   ch = 7'h4C;  // L
      5'd22:   ch = 7'h50;  // P
      5'd23:   ch = 7'h4A;  // J
      5'd24:   ch = 7'h42;  // B
      5'd25:   ch = 7'h58;  // X
      5'd26:   ch = 7'h43;  // C
      5'd27:   ch = 7'h59;  // Y
      5'd28:   ch = 7'h5A;  // Z
      5'd29:   ch = 7'h51;  // Q
      default: ch = CHAR_NONE;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

[sv/mkd_step.sv]
// ---------------------------------------------------------------------------
// Morse keying decoder step logic
// Holds the run and letter state and turns one key sample into up to two
// result items in a single pass.
// ---------------------------------------------------------------------------
`default_nettype none

module mkd_step #(
  parameter int RUN_BITS    = 16,
  parameter int MAX_SYMBOLS = 7
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       go,
  input  wire logic                       key_bit,
  input  wire logic                       end_of_stream,
  input  wire logic [mkd_pkg::DOT_W-1:0]  dot_samples,
  output mkd_pkg::step_res_t              step_out
);

  localparam int CW   = RUN_BITS + 8;
  localparam int SC_W = $clog2(MAX_SYMBOLS + 1);

  logic                       run_open_r, run_open_nxt;
  logic                       run_level_r, run_level_nxt;
  logic [RUN_BITS-1:0]        run_count_r, run_count_nxt;
  logic [mkd_pkg::PAT_W-1:0]  sym_pat_r, sym_pat_nxt;
  logic [SC_W-1:0]            sym_cnt_r, sym_cnt_nxt;
  logic                       sym_ovf_r, sym_ovf_nxt;
  logic                       space_pend_r, space_pend_nxt;

  logic [mkd_pkg::DOT_W-1:0]  dot;
  logic [CW-1:0]              dot_w, two_d, five_d, six_d;
  logic                       same, close_on;
  logic [RUN_BITS-1:0]        prev, cur;
  logic [mkd_pkg::PAT_W-1:0]  pat_a, pat_b;
  logic [SC_W-1:0]            cnt_a, cnt_b;
  logic                       ovf_a, ovf_b;
  logic                       emit, emit_main, cross6;
  logic [4:0]                 idx;
  logic [mkd_pkg::CHAR_W-1:0] tbl_ch, ch;

  // Dot length and the three thresholds as exact integer multiples.
  always_comb begin
    dot    = (dot_samples == '0) ? mkd_pkg::DOT_W'(1) : dot_samples;
    dot_w  = CW'(dot);
    two_d  = dot_w << 1;
    five_d = (dot_w << 2) + dot_w;
    six_d  = (dot_w << 2) + (dot_w << 1);
  end

  // Run measurement with a saturating counter.
  always_comb begin
    same     = run_open_r && (run_level_r == key_bit);
    close_on = run_open_r && run_level_r && !same;
    prev     = same ? run_count_r : '0;
    if (same) begin
      cur = (&run_count_r) ? run_count_r : run_count_r + 1'b1;
    end else begin
      cur = RUN_BITS'(1);
    end
  end

  // Symbol added by a closing on-run, then one closed by end of stream.
  always_comb begin
    pat_a = sym_pat_r;
    cnt_a = sym_cnt_r;
    ovf_a = sym_ovf_r;
    if (close_on) begin
      if (sym_cnt_r >= SC_W'(MAX_SYMBOLS)) begin
        ovf_a = 1'b1;
      end else begin
        pat_a = {sym_pat_r[mkd_pkg::PAT_W-2:0], (CW'(run_count_r) >= two_d)};
        cnt_a = sym_cnt_r + 1'b1;
      end
    end
    pat_b = pat_a;
    cnt_b = cnt_a;
    ovf_b = ovf_a;
    if (end_of_stream && key_bit) begin
      if (cnt_a >= SC_W'(MAX_SYMBOLS)) begin
        ovf_b = 1'b1;
      end else begin
        pat_b = {pat_a[mkd_pkg::PAT_W-2:0], (CW'(cur) >= two_d)};
        cnt_b = cnt_a + 1'b1;
      end
    end
  end

  // Gap thresholds: a letter gap closes the letter, a word gap arms a space.
  always_comb begin
    emit_main = !key_bit && ((CW'(prev) << 1) < five_d) &&
                ((CW'(cur) << 1) >= five_d) && (cnt_a != '0);
    emit      = emit_main || (end_of_stream && (cnt_b != '0));
    cross6    = !key_bit && (CW'(prev) < six_d) && (CW'(cur) >= six_d);
  end

  function automatic logic [4:0] sym_pat_to_idx(input logic [mkd_pkg::PAT_W-1:0] p);
    return p[4:0];
  endfunction

  // Letter lookup; anything too long or not in the table reads as unknown.
  always_comb begin
    idx    = (5'd1 << cnt_b[2:0]) | sym_pat_to_idx(pat_b);
    tbl_ch = mkd_pkg::letter_of(idx);
    ch     = mkd_pkg::CHAR_UNKNOWN;
    if (!ovf_b && (cnt_b >= SC_W'(1)) && (cnt_b <= SC_W'(4)) &&
        (tbl_ch != mkd_pkg::CHAR_NONE)) begin
      ch = tbl_ch;
    end
  end

  // Result items of this sample, pending space first.
  always_comb begin
    step_out = '0;
    if (emit && space_pend_r) begin
      step_out.n   = 2'd2;
      step_out.res[0] = '{char_code: mkd_pkg::CHAR_SPACE, char_valid: 1'b1,
                          last_of_item: 1'b0, end_of_text: 1'b0};
      step_out.res[1] = '{char_code: ch, char_valid: 1'b1,
                          last_of_item: 1'b1, end_of_text: end_of_stream};
    end else if (emit) begin
      step_out.n   = 2'd1;
      step_out.res[0] = '{char_code: ch, char_valid: 1'b1,
                          last_of_item: 1'b1, end_of_text: end_of_stream};
    end else if (end_of_stream) begin
      step_out.n   = 2'd1;
      step_out.res[0] = '{char_code: mkd_pkg::CHAR_NONE, char_valid: 1'b0,
                          last_of_item: 1'b1, end_of_text: 1'b1};
    end
  end

  // Next state; end of stream returns everything to the reset state.
  always_comb begin
    if (end_of_stream) begin
      run_open_nxt   = 1'b0;
      run_level_nxt  = 1'b0;
      run_count_nxt  = '0;
      sym_pat_nxt    = '0;
      sym_cnt_nxt    = '0;
      sym_ovf_nxt    = 1'b0;
      space_pend_nxt = 1'b0;
    end else begin
      run_open_nxt   = 1'b1;
      run_level_nxt  = key_bit;
      run_count_nxt  = cur;
      sym_pat_nxt    = emit ? '0 : pat_b;
      sym_cnt_nxt    = emit ? '0 : cnt_b;
      sym_ovf_nxt    = emit ? 1'b0 : ovf_b;
      space_pend_nxt = (space_pend_r && !emit) || cross6;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_open_r   <= 1'b0;
      run_level_r  <= 1'b0;
      run_count_r  <= '0;
      sym_pat_r    <= '0;
      sym_cnt_r    <= '0;
      sym_ovf_r    <= 1'b0;
      space_pend_r <= 1'b0;
    end else if (go) begin
      run_open_r   <= run_open_nxt;
      run_level_r  <= run_level_nxt;
      run_count_r  <= run_count_nxt;
      sym_pat_r    <= sym_pat_nxt;
      sym_cnt_r    <= sym_cnt_nxt;
      sym_ovf_r    <= sym_ovf_nxt;
      space_pend_r <= space_pend_nxt;
    end
  end

endmodule

`default_nettype wire

[sv/mkd_outq.sv]
// ---------------------------------------------------------------------------
// Morse keying decoder result queue
// A three-entry shift queue that takes zero to two result items per cycle
// and presents one at a time on the result channel.
// ---------------------------------------------------------------------------
`default_nettype none

module mkd_outq (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [1:0]           push_n,
  input  wire mkd_pkg::res_t [1:0]  push_res,
  input  wire logic                 pop,
  output mkd_pkg::res_t             head,
  output logic [1:0]                count
);

  localparam int QD = mkd_pkg::OUTQ_DEPTH;

  mkd_pkg::res_t q_r   [QD];
  mkd_pkg::res_t q_nxt [QD];
  mkd_pkg::res_t sh    [QD];
  logic [1:0]    cnt_r, cnt_nxt;
  logic [1:0]    base;

  // Shift on pop, then place new items right behind the survivors.
  always_comb begin
    base = cnt_r - {1'b0, pop};
    for (int i = 0; i < QD - 1; i++) begin
      sh[i] = q_r[i + 1];
    end
    sh[QD-1] = q_r[QD-1];
    for (int i = 0; i < QD; i++) begin
      q_nxt[i] = pop ? sh[i] : q_r[i];
      if ((2'(i) == base) && (push_n != 2'd0)) begin
        q_nxt[i] = push_res[0];
      end
      if ((2'(i) == base + 2'd1) && (push_n == 2'd2)) begin
        q_nxt[i] = push_res[1];
      end
    end
    cnt_nxt = base + push_n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Payload entries need no reset.
  always_ff @(posedge clk) begin
    for (int i = 0; i < QD; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  assign head  = q_r[0];
  assign count = cnt_r;

endmodule

`default_nettype wire

[sv/morse_keying_decoder.sv]
// An accepted item is held in the input register; its results are written into
// the result queue, whose head drives the output ports.
// Throughput: one item per cycle while each item gives at most one result and
// out_ready stays high; an item giving two results stalls the input register.
// Reset: synchronous active-low rst_n clears the run and letter state and the
// queue and loads a dot length of 100 samples.
// ---------------------------------------------------------------------------
// Morse keying decoder
// Decodes on/off keying samples into letters, spaces and an end marker.
// ---------------------------------------------------------------------------
`default_nettype none

module morse_keying_decoder #(
  parameter int RUN_BITS    = 16,
  parameter int MAX_SYMBOLS = 7
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_wr_en,
  input  wire logic [mkd_pkg::DOT_W-1:0]  cfg_wr_data,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       in_key_bit,
  input  wire logic                       in_end_of_stream,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [mkd_pkg::CHAR_W-1:0]      out_char_code,
  output logic                            out_char_valid,
  output logic                            out_last_of_item,
  output logic                            out_end_of_text
);

  logic [mkd_pkg::DOT_W-1:0] dot_samples_r;
  logic                      in_v_r;
  logic                      key_r, eos_r;
  logic                      proceed, pop;
  logic [1:0]                q_count, push_n;
  mkd_pkg::step_res_t        step_out;
  mkd_pkg::res_t             head;

  // Dot length register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_samples_r <= mkd_pkg::DOT_RESET;
    end else if (cfg_wr_en) begin
      dot_samples_r <= cfg_wr_data;
    end
  end

  // The held item is processed once the queue has room for two results.
  assign proceed  = in_v_r && (q_count <= 2'd1);
  assign in_ready = !in_v_r || proceed;
  assign push_n   = proceed ? step_out.n : 2'd0;
  assign pop      = out_valid && out_ready;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      key_r <= in_key_bit;
      eos_r <= in_end_of_stream;
    end
  end

  mkd_step #(
    .RUN_BITS    (RUN_BITS),
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_step (
    .clk           (clk),
    .rst_n         (rst_n),
    .go            (proceed),
    .key_bit       (key_r),
    .end_of_stream (eos_r),
    .dot_samples   (dot_samples_r),
    .step_out      (step_out)
  );

  mkd_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_n   (push_n),
    .push_res (step_out.res),
    .pop      (pop),
    .head     (head),
    .count    (q_count)
  );

  // Result channel driven from the queue head.
  assign out_valid        = (q_count != 2'd0);
  assign out_char_code    = head.char_code;
  assign out_char_valid   = head.char_valid;
  assign out_last_of_item = head.last_of_item;
  assign out_end_of_text  = head.end_of_text;

  // The end of the text always closes the results of its item.
  a_eot_last : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_text |-> out_last_of_item)
    else $error("end_of_text without last_of_item");

  // A bare marker only appears at the end of the text and carries no code.
  a_bare_marker : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_char_valid |-> out_end_of_text &&
    (out_char_code == mkd_pkg::CHAR_NONE))
    else $error("bare marker outside end of text");

  // A second result is only pushed behind a space.
  a_pair_space : assert property (@(posedge clk) disable iff (!rst_n)
    push_n == 2'd2 |-> step_out.res[0].char_code == mkd_pkg::CHAR_SPACE &&
    !step_out.res[0].last_of_item)
    else $error("two results without a leading space");

  // Pushed results land in the queue without wrapping its count.
  a_queue_room : assert property (@(posedge clk) disable iff (!rst_n)
    proceed && (push_n != 2'd0) |=> q_count != 2'd0)
    else $error("processed item left no room");

endmodule

`default_nettype wire
